@@ sv/swpe_pkg.sv @@
// ----------------------------------------------------------------------------
// swpe_pkg
// Shared widths, datapath command codes and status bundle for the
// swap-based arrangement enumerator.
// ----------------------------------------------------------------------------
package swpe_pkg;

  localparam int unsigned ArraySize = 4;
  localparam int unsigned ElemW     = 2;
  localparam int unsigned IdxW      = 2;
  localparam int unsigned DepthW    = 3;
  localparam int unsigned CountW    = 3;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned ArrW      = ElemW * ArraySize;

  localparam logic [CountW-1:0]  ResetCount      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgElementCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgChooseCount  = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_REWIND,
    CMD_START,
    CMD_DOWN,
    CMD_POP,
    CMD_RESWAP,
    CMD_CAPTURE,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    logic              none;
    logic              in_progress;
    logic              depth_zero;
    logic              depth_lt_r;
    logic              idx_nonzero;
    logic              is_last;
    logic [DepthW-1:0] depth;
  } status_t;

endpackage

@@ sv/swpe_datapath.sv @@
// ----------------------------------------------------------------------------
// swpe_datapath
// Array word, per-level swap indexes, recursion depth, configuration
// registers and the captured result; one swap per cycle on command.
// ----------------------------------------------------------------------------
module swpe_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swpe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [swpe_pkg::CountW-1:0]   cfg_data_i,
  input  swpe_pkg::cmd_e                cmd_i,
  output swpe_pkg::status_t             status_o,
  output logic [swpe_pkg::ArrW-1:0]     res_arr_o,
  output logic                          res_valid_o,
  output logic                          res_last_o
);
  import swpe_pkg::*;

  // element j sits in bits 2j+1..2j
  localparam logic [ArrW-1:0] Identity = 8'b11_10_01_00;

  function automatic logic [ArrW-1:0] swap_elems(input logic [ArrW-1:0] word,
                                                 input logic [IdxW-1:0] a,
                                                 input logic [IdxW-1:0] b);
    logic [ArrW-1:0]  res;
    logic [ElemW-1:0] ea;
    logic [ElemW-1:0] eb;
    ea = word[ElemW*a +: ElemW];
    eb = word[ElemW*b +: ElemW];
    res = word;
    res[ElemW*b +: ElemW] = ea;
    res[ElemW*a +: ElemW] = eb;
    return res;
  endfunction

  logic [CountW-1:0] elem_cnt_q;
  logic [CountW-1:0] choose_q;
  logic [ArrW-1:0]   arr_q, arr_d;
  logic [IdxW-1:0]   idx_q [ArraySize];
  logic [IdxW-1:0]   idx_d [ArraySize];
  logic [DepthW-1:0] depth_q, depth_d;
  logic              prog_q, prog_d;
  logic [IdxW-1:0]   popped_q;
  logic [ArrW-1:0]   res_arr_q;
  logic              res_valid_q;
  logic              res_last_q;

  logic [CountW-1:0] n_sat;
  logic [IdxW-1:0]   cur;
  logic [IdxW-1:0]   below;
  logic [DepthW-1:0] top_down;
  logic [DepthW-1:0] top_pop;
  logic [IdxW-1:0]   reswap_idx;
  logic              none;
  logic              last;

  assign n_sat      = (elem_cnt_q > CountW'(ArraySize)) ? CountW'(ArraySize) : elem_cnt_q;
  assign cur        = depth_q[IdxW-1:0];
  assign below      = IdxW'(depth_q - DepthW'(1));
  // top position of the level being fixed, and of the level just popped
  assign top_down   = n_sat - CountW'(1) - depth_q;
  assign top_pop    = n_sat - depth_q;
  assign reswap_idx = popped_q - IdxW'(1);
  assign none       = choose_q > n_sat;

  always_comb begin
    last = 1'b1;
    for (int j = 0; j < ArraySize; j++) begin
      if ((CountW'(j) < choose_q) && (idx_q[j] != '0)) begin
        last = 1'b0;
      end
    end
  end

  always_comb begin
    arr_d   = arr_q;
    idx_d   = idx_q;
    depth_d = depth_q;
    prog_d  = prog_q;
    case (cmd_i)
      CMD_REWIND: begin
        arr_d   = Identity;
        depth_d = '0;
        prog_d  = 1'b0;
      end
      CMD_START: begin
        depth_d = '0;
        prog_d  = 1'b1;
      end
      CMD_DOWN: begin
        idx_d[cur] = top_down[IdxW-1:0];
        depth_d    = depth_q + DepthW'(1);
      end
      CMD_POP: begin
        arr_d   = swap_elems(arr_q, idx_q[below], top_pop[IdxW-1:0]);
        depth_d = depth_q - DepthW'(1);
      end
      CMD_RESWAP: begin
        idx_d[cur] = reswap_idx;
        arr_d      = swap_elems(arr_q, reswap_idx, top_down[IdxW-1:0]);
        depth_d    = depth_q + DepthW'(1);
      end
      CMD_FINISH: begin
        depth_d = '0;
        prog_d  = 1'b0;
      end
      default: ;
    endcase
    // a register write rewinds the enumeration
    if (cfg_we_i) begin
      arr_d   = Identity;
      depth_d = '0;
      prog_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_cnt_q <= ResetCount;
      choose_q   <= ResetCount;
      arr_q      <= Identity;
      depth_q    <= '0;
      prog_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgElementCount) begin
          elem_cnt_q <= cfg_data_i;
        end else begin
          choose_q <= cfg_data_i;
        end
      end
      arr_q   <= arr_d;
      depth_q <= depth_d;
      prog_q  <= prog_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i == CMD_POP) begin
      popped_q <= idx_q[below];
    end
    if (cmd_i == CMD_CAPTURE) begin
      res_valid_q <= !none;
      res_arr_q   <= none ? '0 : arr_q;
      res_last_q  <= !none && last;
    end
  end

  assign status_o.none        = none;
  assign status_o.in_progress = prog_q;
  assign status_o.depth_zero  = (depth_q == '0);
  assign status_o.depth_lt_r  = (depth_q < choose_q);
  assign status_o.idx_nonzero = (popped_q != '0);
  assign status_o.is_last     = last;
  assign status_o.depth       = depth_q;

  assign res_arr_o   = res_arr_q;
  assign res_valid_o = res_valid_q;
  assign res_last_o  = res_last_q;

endmodule

@@ sv/swpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// swpe_ctrl
// Sequencer that walks the recursion levels: unwinds to the next choice,
// fixes the remaining levels, captures the result and restores after the last.
// ----------------------------------------------------------------------------
module swpe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              restart_i,
  input  logic              out_free_i,
  input  swpe_pkg::status_t status_i,
  output swpe_pkg::cmd_e    cmd_o,
  output logic              load_out_o,
  output logic              in_stall_o
);
  import swpe_pkg::*;

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StDecide   = 3'd1;
  localparam logic [2:0] StAdvCheck = 3'd2;
  localparam logic [2:0] StDescend  = 3'd3;
  localparam logic [2:0] StUnwind   = 3'd4;
  localparam logic [2:0] StEmit     = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    load_out_o = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (restart_i) begin
            cmd_o = CMD_REWIND;
          end
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (status_i.none) begin
          cmd_o   = CMD_CAPTURE;
          state_d = StEmit;
        end else if (!status_i.in_progress) begin
          cmd_o   = CMD_START;
          state_d = StDescend;
        end else if (status_i.depth_zero) begin
          state_d = StDescend;
        end else begin
          cmd_o   = CMD_POP;
          state_d = StAdvCheck;
        end
      end
      // popped level still has a smaller index: take it and go down again
      StAdvCheck: begin
        if (status_i.idx_nonzero) begin
          cmd_o   = CMD_RESWAP;
          state_d = StDescend;
        end else if (status_i.depth_zero) begin
          state_d = StDescend;
        end else begin
          cmd_o = CMD_POP;
        end
      end
      StDescend: begin
        if (status_i.depth_lt_r) begin
          cmd_o = CMD_DOWN;
        end else begin
          cmd_o   = CMD_CAPTURE;
          state_d = status_i.is_last ? StUnwind : StEmit;
        end
      end
      // undo every level so the array is back in its start order
      StUnwind: begin
        if (!status_i.depth_zero) begin
          cmd_o = CMD_POP;
        end else begin
          cmd_o   = CMD_FINISH;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free_i) begin
          load_out_o = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

@@ sv/swap_permutation_enumerator_top.sv @@
// ----------------------------------------------------------------------------
// swap_permutation_enumerator_top
// Steps through the r-arrangements of the first n array positions by swaps.
// Input channel (in_valid_i / in_stall_o, restart_i): each transfer asks for
// one arrangement; restart_i = 1 rewinds to the identity array first.
// Output channel (out_valid_o / out_stall_i): one result per request with the
// packed array, valid_res_o (0 when choose count exceeds the element count
// capped at 4) and last_o on the final arrangement before the order wraps.
// The sequencer does one array swap or level step per cycle, so the time from
// the accepting edge to the result transfer grows with the number of levels
// that are unwound and fixed again, and with any stall on the output.
// One request is worked on at a time; a new one is taken as soon as the
// result sits in the output register, even while that register is stalled.
// A stalled result holds until transferred. Reset gives element count 4,
// choose count 4 and the identity array; a register write also rewinds.
// ----------------------------------------------------------------------------
module swap_permutation_enumerator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swpe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [swpe_pkg::CountW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [swpe_pkg::ArrW-1:0]     arrangement_o,
  output logic                          valid_res_o,
  output logic                          last_o
);
  import swpe_pkg::*;

  cmd_e            cmd;
  status_t         status;
  logic            load_out;
  logic            out_free;
  logic [ArrW-1:0] res_arr;
  logic            res_valid;
  logic            res_last;

  logic            out_valid_q;
  logic [ArrW-1:0] arrangement_q;
  logic            valid_res_q;
  logic            last_q;

  assign out_free = !out_valid_q || !out_stall_i;

  swpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd),
    .load_out_o (load_out),
    .in_stall_o (in_stall_o)
  );

  swpe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_arr_o   (res_arr),
    .res_valid_o (res_valid),
    .res_last_o  (res_last)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      arrangement_q <= res_arr;
      valid_res_q   <= res_valid;
      last_q        <= res_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign arrangement_o = arrangement_q;
  assign valid_res_o   = valid_res_q;
  assign last_o        = last_q;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while previous one still in work");

  a_empty_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (!last_o && (arrangement_o == '0)))
    else $error("result without arrangement carries data");

  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.depth <= DepthW'(ArraySize))
    else $error("recursion depth beyond array size");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("output register overwritten while stalled");
`endif

endmodule
